// ===== design/text_console_writer_assert.svh =====
// assertion helpers shared by the console writer
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TCW_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("console writer check failed");

// next-cycle implication, checked out of reset
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

// ===== design/tcw_pkg.sv =====
package tcw_pkg;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [15:0] RESET_CELL   = 16'h0720;

    localparam logic REQ_PUT   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic REG_FORE = 1'b0;
    localparam logic REG_BACK = 1'b1;

    localparam int OUT_DATA_W = 56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_SCROLL_TAIL,
        ST_FILL,
        ST_WRITE,
        ST_RESULT
    } tcw_state_t;

    typedef struct packed {
        logic        did_scroll;
        logic [15:0] cell_value;
        logic [10:0] cell_address;
        logic        cell_written;
        logic [10:0] cursor_position;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
    } tcw_result_t;

endpackage

// ===== design/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tcw_seq.sv =====
module tcw_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_req,
    input  logic [7:0]           in_code,
    input  logic [3:0]           fore_color,
    input  logic [3:0]           back_color,
    output logic                 res_valid,
    input  logic                 res_ready,
    output tcw_pkg::tcw_result_t res
);

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int XW    = (PW > 11) ? PW : 11;
    localparam int CXW   = (CW > 7) ? CW : 7;

    localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COPY_START    = AW'(COLUMNS);
    localparam logic [AW-1:0] ROW_STRIDE    = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_END       = CW'(COLUMNS);

    tcw_state_t      state_reg, state_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic            req_reg, req_next;
    logic [7:0]      code_reg, code_next;
    logic [AW-1:0]   scan_reg, scan_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;
    logic [15:0]     fill_val_reg, fill_val_next;
    logic            written_reg, written_next;
    logic            scrolled_reg, scrolled_next;
    logic            init_reg, init_next;
    logic [AW-1:0]   cell_addr_reg, cell_addr_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    logic [15:0]     blank_cell;
    logic [15:0]     char_cell;
    logic [AW-1:0]   cur_addr;
    logic [XW-1:0]   pos_x;
    logic [XW-1:0]   addr_x;
    logic [CXW-1:0]  col_x;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign blank_cell = {back_color, fore_color, SPACE_CODE};
    assign char_cell  = {back_color, fore_color, code_reg};
    assign cur_addr   = AW'(row_reg) * ROW_STRIDE + AW'(col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            row_reg       <= '0;
            col_reg       <= '0;
            req_reg       <= REQ_PUT;
            code_reg      <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            fill_val_reg  <= RESET_CELL;
            written_reg   <= 1'b0;
            scrolled_reg  <= 1'b0;
            init_reg      <= 1'b1;
            cell_addr_reg <= '0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            req_reg       <= req_next;
            code_reg      <= code_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            fill_val_reg  <= fill_val_next;
            written_reg   <= written_next;
            scrolled_reg  <= scrolled_next;
            init_reg      <= init_next;
            cell_addr_reg <= cell_addr_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        req_next       = req_reg;
        code_next      = code_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        fill_val_next  = fill_val_reg;
        written_next   = written_reg;
        scrolled_next  = scrolled_reg;
        init_next      = init_reg;
        cell_addr_next = cell_addr_reg;
        ram_we         = 1'b0;
        ram_waddr      = scan_reg;
        ram_wdata      = fill_val_reg;
        ram_re         = 1'b0;
        ram_raddr      = scan_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next   = in_req;
                    code_next  = in_code;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                scrolled_next  = 1'b0;
                cell_addr_next = '0;
                written_next   = 1'b0;
                if (req_reg == REQ_CLEAR) begin
                    row_next      = '0;
                    col_next      = '0;
                    fill_val_next = blank_cell;
                    scan_next     = '0;
                    state_next    = ST_FILL;
                end else begin
                    written_next = (code_reg != NEWLINE_CODE);
                    // newline always moves down; other bytes only when past the last column
                    if (code_reg == NEWLINE_CODE || col_reg >= COL_END) begin
                        col_next = '0;
                        if (row_reg == LAST_ROW) begin
                            scrolled_next = 1'b1;
                            scan_next     = COPY_START;
                            pend_next     = 1'b0;
                            state_next    = ST_SCROLL;
                        end else begin
                            row_next   = row_reg + RW'(1);
                            state_next = (code_reg == NEWLINE_CODE) ? ST_RESULT : ST_WRITE;
                        end
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_SCROLL: begin
                // read one cell ahead, write the previous read one row up
                ram_re         = 1'b1;
                ram_raddr      = scan_reg;
                ram_we         = pend_reg;
                ram_waddr      = pend_addr_reg;
                ram_wdata      = ram_rdata;
                pend_next      = 1'b1;
                pend_addr_next = scan_reg - ROW_STRIDE;
                if (scan_reg == LAST_CELL) begin
                    state_next = ST_SCROLL_TAIL;
                end else begin
                    scan_next = scan_reg + AW'(1);
                end
            end

            ST_SCROLL_TAIL: begin
                ram_we        = 1'b1;
                ram_waddr     = pend_addr_reg;
                ram_wdata     = ram_rdata;
                pend_next     = 1'b0;
                fill_val_next = blank_cell;
                scan_next     = LAST_ROW_BASE;
                state_next    = ST_FILL;
            end

            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = fill_val_reg;
                if (scan_reg == LAST_CELL) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else if (written_reg) begin
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    scan_next = scan_reg + AW'(1);
                end
            end

            ST_WRITE: begin
                ram_we         = 1'b1;
                ram_waddr      = cur_addr;
                ram_wdata      = char_cell;
                cell_addr_next = cur_addr;
                col_next       = col_reg + CW'(1);
                state_next     = ST_RESULT;
            end

            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pos_x  = XW'(row_reg) * XW'(COLUMNS) + XW'(col_reg);
    assign addr_x = XW'(cell_addr_reg);
    assign col_x  = CXW'(col_reg);

    always_comb begin
        res.cursor_row      = 5'(row_reg);
        res.cursor_col      = col_x[6:0];
        res.cursor_position = pos_x[10:0];
        res.cell_written    = written_reg;
        res.cell_address    = written_reg ? addr_x[10:0] : 11'd0;
        res.cell_value      = written_reg ? char_cell : 16'd0;
        res.did_scroll      = scrolled_reg;
    end

endmodule

// ===== design/text_console_writer.sv =====
// Teletype console writer over a ROWS x COLUMNS text screen held in one
// single-port-write, registered-read memory. After reset every cell is filled
// with a grey space, during which s_tready stays low (configuration writes
// are still taken). A printable character passes the exec and write states
// before its result is offered, a newline the exec state only; an item that
// scrolls first copies every cell from the second row on one row up and
// blanks the last row, one cell per cycle through the memory port. A clear
// item blanks every cell before its result. One item is in work at a time;
// the result waits in an output register, so the next item may be taken
// before it is drained. Colors live at byte 0 (foreground) and 4 (background).
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic        s_tuser,   // req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    // cursor_row, cursor_col, cursor_position, cell_written, cell_address,
    // cell_value, did_scroll, zero pad
    output logic [55:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import tcw_pkg::*;

    logic [3:0]                    fore_reg;
    logic [3:0]                    back_reg;
    logic                          m_tvalid_reg;
    logic [OUT_DATA_W-1:0]         m_tdata_reg;
    logic                          res_valid;
    logic                          res_ready;
    tcw_result_t                   res;
    logic                          cfg_write;
    logic                          reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_sel   = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fore_reg <= 4'd7;
            back_reg <= 4'd0;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_FORE: fore_reg <= pwdata[3:0];
                REG_BACK: back_reg <= pwdata[3:0];
                default:  fore_reg <= fore_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FORE: prdata = {28'd0, fore_reg};
            REG_BACK: prdata = {28'd0, back_reg};
            default:  prdata = 32'd0;
        endcase
    end

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (s_tuser),
        .in_code    (s_tdata),
        .fore_color (fore_reg),
        .back_color (back_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output slot is free when empty or drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {4'd0, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `include "text_console_writer_assert.svh"

    `TCW_ASSERT_IMPLIES(a_col_range, aclk, aresetn, res_valid, 32'(res.cursor_col) <= COLUMNS)
    `TCW_ASSERT_IMPLIES(a_row_range, aclk, aresetn, res_valid, 32'(res.cursor_row) < ROWS)
    `TCW_ASSERT_IMPLIES(a_no_cell, aclk, aresetn, res_valid && !res.cell_written, res.cell_address == 11'd0 && res.cell_value == 16'd0)
    `TCW_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

// ===== dv/text_console_writer_tb.sv =====
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELLS          = COLUMNS * ROWS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // char_code
    logic        s_tuser  = 1'b0; // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    // cursor_row, cursor_col, cursor_position, cell_written, cell_address,
    // cell_value, did_scroll, zero pad
    logic [55:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // cursor and color state as the writer should hold it
    int          cur_row = 0;
    int          cur_col = 0;
    logic [3:0]  fore_q  = 4'd7;
    logic [3:0]  back_q  = 4'd0;

    tcw_result_t console_report_q[$];

    bit          idle_on = 1'b1;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          errors = 0;
    int          n_checked = 0;
    int          n_char = 0;
    int          n_wrap = 0;
    int          n_newline = 0;
    int          n_clear = 0;
    int          n_scroll = 0;
    int          n_cfg = 0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // moves to column 0 of the next row, returns 1 when the screen scrolls
    function automatic logic line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            cur_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic tcw_result_t predict_report(input logic req, input logic [7:0] code);
        tcw_result_t r;
        int          addr;
        int          pos;
        r = '0;
        if (req == REQ_CLEAR) begin
            cur_row = 0;
            cur_col = 0;
            n_clear++;
        end else if (code == NEWLINE_CODE) begin
            r.did_scroll = line_feed();
            n_newline++;
        end else begin
            if (cur_col >= COLUMNS) begin
                r.did_scroll = line_feed();
                n_wrap++;
            end
            addr = cur_row * COLUMNS + cur_col;
            if (addr >= CELLS)
                addr = CELLS - 1;
            r.cell_written = 1'b1;
            r.cell_address = addr[10:0];
            r.cell_value   = {back_q, fore_q, code};
            cur_col++;
            n_char++;
        end
        pos = cur_row * COLUMNS + cur_col;
        r.cursor_row      = cur_row[4:0];
        r.cursor_col      = cur_col[6:0];
        r.cursor_position = pos[10:0];
        if (r.did_scroll)
            n_scroll++;
        return r;
    endfunction

    function automatic logic [7:0] rand_glyph();
        logic [7:0] code;
        do
            code = 8'($urandom_range(0, 255));
        while (code == NEWLINE_CODE);
        return code;
    endfunction

    // valid stays high after the transfer, so back-to-back items are sent without lowering it
    task automatic send_item(input logic req, input logic [7:0] code);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= code;
        do
            @(posedge aclk);
        while (!s_tready);
        console_report_q.push_back(predict_report(req, code));
    endtask

    task automatic send_glyphs(input int count);
        repeat (count) send_item(REQ_PUT, rand_glyph());
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (console_report_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic reg_idx, input logic [3:0] value);
        logic [27:0] junk;
        junk = 28'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {junk, value};
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_FORE)
            fore_q = value;
        else
            back_q = value;
        n_cfg++;
        @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d (0x%0h) actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        tcw_result_t got;
        tcw_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(tcw_result_t)-1:0];
            if (console_report_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual 0x%0h", $time, m_tdata);
                errors++;
            end else begin
                want = console_report_q.pop_front();
                check_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
                check_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
                check_field("cursor_position", 32'(want.cursor_position),
                            32'(got.cursor_position));
                check_field("cell_written", 32'(want.cell_written), 32'(got.cell_written));
                check_field("cell_address", 32'(want.cell_address), 32'(got.cell_address));
                check_field("cell_value", 32'(want.cell_value), 32'(got.cell_value));
                check_field("did_scroll", 32'(want.did_scroll), 32'(got.did_scroll));
                n_checked++;
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // reset fill, a clear and a scroll each walk the screen memory with no transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_char_extremes();
        send_item(REQ_PUT, 8'h00);
        send_item(REQ_PUT, 8'hFF);
        send_item(REQ_PUT, 8'h80);
        send_item(REQ_PUT, 8'h7F);
        send_item(REQ_PUT, SPACE_CODE);
        send_item(REQ_PUT, 8'h55);
        send_item(REQ_PUT, 8'hAA);
        send_item(REQ_PUT, NEWLINE_CODE);
        send_item(REQ_PUT, 8'h41);
        send_item(REQ_CLEAR, 8'hFF);
        send_item(REQ_PUT, 8'h0B);
        send_item(REQ_CLEAR, NEWLINE_CODE);
        send_item(REQ_PUT, 8'h09);
        drain_results();
    endtask

    task automatic test_newline_scroll();
        send_item(REQ_CLEAR, 8'h00);
        // the last of these runs off the bottom row
        repeat (ROWS) send_item(REQ_PUT, NEWLINE_CODE);
        send_item(REQ_PUT, NEWLINE_CODE);
        send_glyphs(3);
        send_item(REQ_PUT, NEWLINE_CODE);
        drain_results();
    endtask

    task automatic test_wrap();
        send_item(REQ_CLEAR, 8'h5A);
        send_glyphs(COLUMNS);
        // column is now past the end, next glyph wraps
        send_glyphs(1);
        send_item(REQ_PUT, NEWLINE_CODE);
        repeat (ROWS) send_item(REQ_PUT, NEWLINE_CODE);
        // fill the bottom row, then wrap and scroll in one item
        send_glyphs(COLUMNS + 1);
        send_item(REQ_PUT, NEWLINE_CODE);
        drain_results();
    endtask

    task automatic test_colors();
        cfg_write(REG_FORE, 4'hF);
        cfg_write(REG_BACK, 4'hF);
        send_glyphs(4);
        send_item(REQ_PUT, NEWLINE_CODE);
        drain_results();
        cfg_write(REG_FORE, 4'h0);
        cfg_write(REG_BACK, 4'h0);
        send_glyphs(3);
        drain_results();
        cfg_write(REG_BACK, 4'hA);
        cfg_write(REG_FORE, 4'h5);
        send_item(REQ_CLEAR, 8'h00);
        send_glyphs(3);
        drain_results();
    endtask

    task automatic test_random();
        int phase;
        int roll;
        int nl_pct;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    cfg_write(REG_FORE, 4'hF);
                    cfg_write(REG_BACK, 4'h0);
                    nl_pct = 25;
                end
                1: begin
                    cfg_write(REG_FORE, 4'h0);
                    cfg_write(REG_BACK, 4'hF);
                    nl_pct = 2;
                end
                default: begin
                    cfg_write(REG_FORE, 4'($urandom_range(0, 15)));
                    cfg_write(REG_BACK, 4'($urandom_range(0, 15)));
                    nl_pct = (phase == 3) ? 5 : 12;
                end
            endcase
            // no idling on either side in the last phase
            idle_on = (phase < 4);
            repeat (30) begin
                roll = $urandom_range(0, 99);
                if (roll < 1)
                    send_item(REQ_CLEAR, 8'($urandom_range(0, 255)));
                else if (roll < 1 + nl_pct)
                    send_item(REQ_PUT, NEWLINE_CODE);
                else
                    send_item(REQ_PUT, 8'($urandom_range(0, 255)));
            end
            drain_results();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_char_extremes();
        test_newline_scroll();
        test_wrap();
        test_colors();
        test_random();
        repeat (20) @(posedge aclk);
        $display("covered %0d glyphs (%0d wrapped), %0d newlines, %0d clears, %0d scrolls",
                 n_char, n_wrap, n_newline, n_clear, n_scroll);
        $display("%0d results checked across %0d color writes, %0d mismatches",
                 n_checked, n_cfg, errors);
        if (errors == 0 && console_report_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
